FILE: design/variable_record_ring_buffer_defines.svh
// Assertion macros for the variable record ring buffer.
// Depends on clk_i and rst_ni in the module that uses them.
`ifndef VARIABLE_RECORD_RING_BUFFER_DEFINES_SVH
`define VARIABLE_RECORD_RING_BUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
`define VRRB_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define VRRB_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);
`else
`define VRRB_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define VRRB_ASSERT_NEVER(lbl, expr, msg)
`endif
`endif

FILE: design/vrrb_pkg.sv
// Shared types and codes of the variable record ring buffer.
// No dependencies.
package vrrb_pkg;

  localparam int unsigned CapacityBytesDefault = 2048;

  localparam logic [2:0] CmdWriteBegin = 3'd0;
  localparam logic [2:0] CmdPayload    = 3'd1;
  localparam logic [2:0] CmdRead       = 3'd2;
  localparam logic [2:0] CmdUnblock    = 3'd3;
  localparam logic [2:0] CmdNextId     = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StError = 2'd2;
  localparam logic [1:0] StNone  = 2'd3;

  localparam logic [31:0] PadType = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_PAYLOAD,
    OP_READ,
    OP_UNBLOCK,
    OP_NEXT_ID,
    OP_REJECT
  } op_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [30:0] msg_type;
    logic [11:0] msg_length;
    logic [63:0] data_word;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [30:0] out_type;
    logic [8:0]  out_length;
    logic [10:0] rec_index;
    logic [63:0] out_data;
    logic [62:0] correlation_id;
    logic        last;
  } out_t;

  typedef struct packed {
    op_e         op;
    logic [30:0] msg_type;
    logic [11:0] msg_length;
    logic [63:0] data_word;
  } q_entry_t;

endpackage

FILE: design/vrrb_queue.sv
// Two-entry command queue between the front and back parts.
// Depends on vrrb_pkg.
module vrrb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  vrrb_pkg::q_entry_t entry_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               valid_o,
  output vrrb_pkg::q_entry_t entry_o
);
  import vrrb_pkg::*;

  q_entry_t   slot_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign entry_o = slot_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

endmodule

FILE: design/vrrb_front.sv
// Front part: takes commands and classifies them into queue entries.
// Depends on vrrb_pkg.
module vrrb_front #(
  parameter int unsigned CAPACITY_BYTES = vrrb_pkg::CapacityBytesDefault
) (
  input  logic               start_i,
  input  vrrb_pkg::in_t      req_i,
  output logic               busy_o,
  input  logic               clear_done_i,
  input  logic               q_full_i,
  output logic               push_o,
  output vrrb_pkg::q_entry_t entry_o
);
  import vrrb_pkg::*;

  localparam int unsigned RingWords = CAPACITY_BYTES / 8;

  logic too_long;

  assign busy_o   = q_full_i || !clear_done_i;
  assign push_o   = start_i && !busy_o;
  assign too_long = ({20'd0, req_i.msg_length} > 32'(RingWords));

  always_comb begin
    entry_o.msg_type   = req_i.msg_type;
    entry_o.msg_length = req_i.msg_length;
    entry_o.data_word  = req_i.data_word;
    unique case (req_i.command)
      CmdWriteBegin: begin
        entry_o.op = (too_long || req_i.msg_type == 31'd0) ? OP_REJECT : OP_WRITE;
      end
      CmdPayload: entry_o.op = OP_PAYLOAD;
      CmdRead:    entry_o.op = OP_READ;
      CmdUnblock: entry_o.op = OP_UNBLOCK;
      CmdNextId:  entry_o.op = OP_NEXT_ID;
      default:    entry_o.op = OP_REJECT;
    endcase
  end

endmodule

FILE: design/vrrb_back.sv
// Back part: executes queued commands against the ring store and emits results.
// Depends on vrrb_pkg.
module vrrb_back #(
  parameter int unsigned CAPACITY_BYTES = vrrb_pkg::CapacityBytesDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  vrrb_pkg::q_entry_t q_entry_i,
  output logic               q_pop_o,
  output logic               clear_done_o,
  output logic               res_valid_o,
  output vrrb_pkg::out_t     res_o
);
  import vrrb_pkg::*;

  localparam int unsigned RingWords = CAPACITY_BYTES / 8;
  localparam int unsigned AW = $clog2(RingWords);
  localparam int unsigned PW = AW + 1;
  localparam int unsigned ML = AW + 1;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_WB_HDR   = 12'b0000_0000_0100,
    S_COMMIT   = 12'b0000_0000_1000,
    S_RD_ISSUE = 12'b0000_0001_0000,
    S_RD_CHK   = 12'b0000_0010_0000,
    S_RD_WADDR = 12'b0000_0100_0000,
    S_RD_WEMIT = 12'b0000_1000_0000,
    S_RD_CLR   = 12'b0001_0000_0000,
    S_UB_CHK   = 12'b0010_0000_0000,
    S_UB_ISSUE = 12'b0100_0000_0000,
    S_UB_SCAN  = 12'b1000_0000_0000
  } state_e;

  function automatic logic [63:0] mask_bytes(logic [63:0] d, logic [ML-1:0] rem);
    logic [63:0] r;
    r = d;
    for (int b = 0; b < 8; b++) begin
      if (rem < ML'(b + 1)) begin
        r[8*b +: 8] = 8'h00;
      end
    end
    return r;
  endfunction

  function automatic logic [ML-1:0] rem_less8(logic [ML-1:0] rem);
    return (rem >= ML'(8)) ? rem - ML'(8) : '0;
  endfunction

  logic [63:0] mem [RingWords];
  logic [63:0] rdata_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [63:0] mem_wdata;

  state_e      state_q, state_d;
  logic [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic [62:0] corr_q, corr_d;
  logic [AW-1:0] open_hdr_q, open_hdr_d, open_wptr_q, open_wptr_d;
  logic [PW-1:0] open_left_q, open_left_d;
  logic [ML-1:0] open_rem_q, open_rem_d, open_len_q, open_len_d;
  logic [30:0] open_type_q, open_type_d;
  logic [63:0] hdr_q, hdr_d;
  logic [AW-1:0] base_q, base_d, rd_ptr_q, rd_ptr_d;
  logic [PW-1:0] bytes_q, bytes_d, rd_left_q, rd_left_d, clr_q, clr_d;
  logic [30:0] msg_type_q, msg_type_d;
  logic [ML-1:0] msg_len_q, msg_len_d, rd_rem_q, rd_rem_d;
  logic [PW-1:0] ub_i_q, ub_i_d, ub_limit_q, ub_limit_d;
  out_t        res_q, res_d;
  logic        res_valid_q, res_valid_d;

  // claim arithmetic, in words but for the header and pad lengths, which are in bytes
  q_entry_t    ent;
  logic [AW-1:0] head_idx, tail_idx, claim_idx;
  logic [PW-1:0] used, avail, to_end, req_w, words_w, tail_next, contig, limit;
  logic        wrap, claim_ok;
  logic [31:0] rec32, hdr_len;
  logic [63:0] pad_word, hdr_word;
  // read scan arithmetic
  logic [31:0] lo, hi;
  logic [29:0] align_w;
  logic [33:0] nb_sum;
  logic [PW-1:0] nb, msg_words;
  logic [ML-1:0] msg_len;
  logic [31:0] lo_m8;

  assign ent       = q_entry_i;
  assign head_idx  = head_q[AW-1:0];
  assign tail_idx  = tail_q[AW-1:0];
  assign used      = tail_q - head_q;
  assign avail     = PW'(RingWords) - used;
  assign to_end    = PW'(RingWords) - {1'b0, tail_idx};
  assign req_w     = PW'(({1'b0, ent.msg_length} + 13'd15) >> 3);
  assign words_w   = PW'(({1'b0, ent.msg_length} + 13'd7) >> 3);
  assign wrap      = (req_w > to_end);
  assign claim_ok  = !(req_w > avail) && !(wrap && (req_w > {1'b0, head_idx}));
  assign tail_next = tail_q + req_w + (wrap ? to_end : '0);
  assign claim_idx = wrap ? '0 : tail_idx;
  assign rec32     = {20'd0, ent.msg_length} + 32'd8;
  assign hdr_len   = (ent.msg_length == 12'd0) ? rec32 : (32'd0 - rec32);
  assign hdr_word  = {1'b0, ent.msg_type, hdr_len};
  assign pad_word  = {PadType, 32'({to_end, 3'b000})};

  assign lo        = rdata_q[31:0];
  assign hi        = rdata_q[63:32];
  assign align_w   = 30'(({1'b0, lo} + 33'd7) >> 3);
  assign contig    = PW'(RingWords) - {1'b0, base_q};
  assign nb_sum    = 34'(bytes_q) + 34'(align_w);
  assign nb        = (nb_sum > 34'(contig)) ? contig : PW'(nb_sum);
  assign lo_m8     = lo - 32'd8;
  assign msg_len   = (lo < 32'd8) ? '0 :
                     (lo_m8 > 32'(RingWords)) ? ML'(RingWords) : ML'(lo_m8);
  assign msg_words = PW'(({1'b0, msg_len} + (ML + 1)'(7)) >> 3);
  assign limit     = (tail_idx > head_idx) ? {1'b0, tail_idx} : PW'(RingWords);

  assign clear_done_o = (state_q != S_CLEAR);
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end else if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    corr_d      = corr_q;
    open_hdr_d  = open_hdr_q;
    open_wptr_d = open_wptr_q;
    open_left_d = open_left_q;
    open_rem_d  = open_rem_q;
    open_len_d  = open_len_q;
    open_type_d = open_type_q;
    hdr_d       = hdr_q;
    base_d      = base_q;
    rd_ptr_d    = rd_ptr_q;
    bytes_d     = bytes_q;
    rd_left_d   = rd_left_q;
    clr_d       = clr_q;
    msg_type_d  = msg_type_q;
    msg_len_d   = msg_len_q;
    rd_rem_d    = rd_rem_q;
    ub_i_d      = ub_i_q;
    ub_limit_d  = ub_limit_q;
    res_d       = '0;
    res_d.last  = 1'b1;
    res_valid_d = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = '0;
    mem_wdata   = '0;
    q_pop_o     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q[AW-1:0];
        clr_d    = clr_q + PW'(1);
        if (clr_q[AW-1:0] == AW'(RingWords - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          unique case (ent.op)
            OP_WRITE: begin
              res_valid_d = 1'b1;
              if (!claim_ok) begin
                res_d.status = StFull;
              end else begin
                res_d.status    = StOk;
                res_d.rec_index = 11'({claim_idx, 3'b000});
                tail_d      = tail_next;
                open_hdr_d  = claim_idx;
                open_wptr_d = claim_idx + AW'(1);
                open_left_d = words_w;
                open_rem_d  = ML'(ent.msg_length);
                open_len_d  = ML'(ent.msg_length);
                open_type_d = ent.msg_type;
                hdr_d       = hdr_word;
                mem_we      = 1'b1;
                if (wrap) begin
                  // padding to the end first, header at index 0 next cycle
                  mem_addr  = tail_idx;
                  mem_wdata = pad_word;
                  state_d   = S_WB_HDR;
                end else begin
                  mem_addr  = claim_idx;
                  mem_wdata = hdr_word;
                end
              end
            end
            OP_PAYLOAD: begin
              res_valid_d = 1'b1;
              if (open_left_q == '0) begin
                res_d.status = StError;
              end else begin
                res_d.status    = StOk;
                res_d.rec_index = 11'({open_hdr_q, 3'b000});
                mem_we      = 1'b1;
                mem_addr    = open_wptr_q;
                mem_wdata   = mask_bytes(ent.data_word, open_rem_q);
                open_wptr_d = open_wptr_q + AW'(1);
                open_left_d = open_left_q - PW'(1);
                open_rem_d  = rem_less8(open_rem_q);
                if (open_left_q == PW'(1)) begin
                  state_d = S_COMMIT;
                end
              end
            end
            OP_READ: begin
              base_d  = head_idx;
              bytes_d = '0;
              state_d = S_RD_ISSUE;
            end
            OP_UNBLOCK: begin
              if (head_q == tail_q) begin
                res_valid_d  = 1'b1;
                res_d.status = StNone;
              end else begin
                mem_re   = 1'b1;
                mem_addr = head_idx;
                state_d  = S_UB_CHK;
              end
            end
            OP_NEXT_ID: begin
              res_valid_d          = 1'b1;
              res_d.status         = StOk;
              res_d.correlation_id = corr_q;
              corr_d               = corr_q + 63'd1;
            end
            default: begin
              res_valid_d  = 1'b1;
              res_d.status = StError;
            end
          endcase
        end
      end
      S_WB_HDR: begin
        mem_we    = 1'b1;
        mem_addr  = open_hdr_q;
        mem_wdata = hdr_q;
        state_d   = S_IDLE;
      end
      S_COMMIT: begin
        mem_we    = 1'b1;
        mem_addr  = open_hdr_q;
        mem_wdata = {1'b0, open_type_q, 32'(open_len_q) + 32'd8};
        state_d   = S_IDLE;
      end
      S_RD_ISSUE: begin
        clr_d = '0;
        if (bytes_q < contig) begin
          mem_re   = 1'b1;
          mem_addr = base_q + bytes_q[AW-1:0];
          state_d  = S_RD_CHK;
        end else begin
          res_valid_d  = 1'b1;
          res_d.status = StNone;
          state_d      = S_RD_CLR;
        end
      end
      S_RD_CHK: begin
        if (lo == 32'd0 || lo[31]) begin
          res_valid_d  = 1'b1;
          res_d.status = StNone;
          state_d      = S_RD_CLR;
        end else begin
          bytes_d = nb;
          if (hi == PadType) begin
            state_d = S_RD_ISSUE;
          end else begin
            msg_type_d       = hi[30:0];
            msg_len_d        = msg_len;
            rd_ptr_d         = base_q + bytes_q[AW-1:0] + AW'(1);
            rd_left_d        = msg_words;
            rd_rem_d         = msg_len;
            res_valid_d      = 1'b1;
            res_d.status     = StOk;
            res_d.out_type   = hi[30:0];
            res_d.out_length = 9'(msg_len);
            res_d.last       = (msg_words == '0);
            state_d          = (msg_words == '0) ? S_RD_CLR : S_RD_WADDR;
          end
        end
      end
      S_RD_WADDR: begin
        mem_re   = 1'b1;
        mem_addr = rd_ptr_q;
        state_d  = S_RD_WEMIT;
      end
      S_RD_WEMIT: begin
        res_valid_d      = 1'b1;
        res_d.status     = StOk;
        res_d.out_type   = msg_type_q;
        res_d.out_length = 9'(msg_len_q);
        res_d.out_data   = mask_bytes(rdata_q, rd_rem_q);
        res_d.last       = (rd_left_q == PW'(1));
        rd_ptr_d         = rd_ptr_q + AW'(1);
        rd_left_d        = rd_left_q - PW'(1);
        rd_rem_d         = rem_less8(rd_rem_q);
        state_d          = (rd_left_q == PW'(1)) ? S_RD_CLR : S_RD_WADDR;
      end
      S_RD_CLR: begin
        // zero the consumed words, then advance the head
        if (clr_q < bytes_q) begin
          mem_we   = 1'b1;
          mem_addr = base_q + clr_q[AW-1:0];
          clr_d    = clr_q + PW'(1);
        end else begin
          head_d  = head_q + bytes_q;
          state_d = S_IDLE;
        end
      end
      S_UB_CHK: begin
        if (lo[31]) begin
          mem_we       = 1'b1;
          mem_addr     = head_idx;
          mem_wdata    = {PadType, 32'd0 - lo};
          res_valid_d  = 1'b1;
          res_d.status = StOk;
          if (open_left_q != '0 && open_hdr_q == head_idx) begin
            open_left_d = '0;
          end
          state_d = S_IDLE;
        end else if (lo != 32'd0) begin
          res_valid_d  = 1'b1;
          res_d.status = StNone;
          state_d      = S_IDLE;
        end else begin
          ub_i_d     = {1'b0, head_idx} + PW'(1);
          ub_limit_d = limit;
          state_d    = S_UB_ISSUE;
        end
      end
      S_UB_ISSUE: begin
        if (ub_i_q < ub_limit_q) begin
          mem_re   = 1'b1;
          mem_addr = ub_i_q[AW-1:0];
          state_d  = S_UB_SCAN;
        end else begin
          res_valid_d  = 1'b1;
          res_d.status = StNone;
          state_d      = S_IDLE;
        end
      end
      S_UB_SCAN: begin
        if (lo != 32'd0) begin
          mem_we       = 1'b1;
          mem_addr     = head_idx;
          mem_wdata    = {PadType, 32'({ub_i_q - {1'b0, head_idx}, 3'b000})};
          res_valid_d  = 1'b1;
          res_d.status = StOk;
          state_d      = S_IDLE;
        end else begin
          ub_i_d  = ub_i_q + PW'(1);
          state_d = S_UB_ISSUE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      head_q      <= '0;
      tail_q      <= '0;
      corr_q      <= '0;
      open_left_q <= '0;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      corr_q      <= corr_d;
      open_left_q <= open_left_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    open_hdr_q  <= open_hdr_d;
    open_wptr_q <= open_wptr_d;
    open_rem_q  <= open_rem_d;
    open_len_q  <= open_len_d;
    open_type_q <= open_type_d;
    hdr_q       <= hdr_d;
    base_q      <= base_d;
    rd_ptr_q    <= rd_ptr_d;
    bytes_q     <= bytes_d;
    rd_left_q   <= rd_left_d;
    msg_type_q  <= msg_type_d;
    msg_len_q   <= msg_len_d;
    rd_rem_q    <= rd_rem_d;
    ub_i_q      <= ub_i_d;
    ub_limit_q  <= ub_limit_d;
    res_q       <= res_d;
  end

endmodule

FILE: design/variable_record_ring_buffer.sv
// Variable-length record ring buffer: front classifier, queue and back executor.
// Depends on vrrb_pkg, vrrb_front, vrrb_queue, vrrb_back and the defines header.
//
// A command is taken when start_i is high and busy_o low; up to two commands wait
// in a queue while the back part works on one. Results come on res_o for one cycle,
// marked by res_valid_o, and cannot be held off. After reset the store is cleared
// one word a cycle, all CAPACITY_BYTES/8 words (256 by default), with busy_o high.
// The single-port store sets the order of work: a write begin writes the header, or
// at the wrap the padding word and then the header; a payload word is written, and
// the last one also commits the header. A read reads and checks each header from the
// head, emits the header beat and each payload word, then zeroes the consumed words
// and advances the head. An unblock answers an empty ring without a store access,
// else reads the head header and may scan the words past it.
`include "variable_record_ring_buffer_defines.svh"

module variable_record_ring_buffer #(
  parameter int unsigned CAPACITY_BYTES = vrrb_pkg::CapacityBytesDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  vrrb_pkg::in_t  req_i,
  output logic           busy_o,
  output logic           res_valid_o,
  output vrrb_pkg::out_t res_o
);
  import vrrb_pkg::*;

  logic     clear_done, q_full, q_push, q_pop, q_valid;
  logic     res_fail;
  q_entry_t push_entry, head_entry;

  vrrb_front #(.CAPACITY_BYTES(CAPACITY_BYTES)) u_front (
    .start_i     (start_i),
    .req_i       (req_i),
    .busy_o      (busy_o),
    .clear_done_i(clear_done),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .entry_o     (push_entry)
  );

  vrrb_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(push_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .entry_o(head_entry)
  );

  vrrb_back #(.CAPACITY_BYTES(CAPACITY_BYTES)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .clear_done_o(clear_done),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  assign res_fail = res_valid_o && (res_o.status != StOk);

  `VRRB_ASSERT_IMPLIES(a_fail_single, res_fail, res_o.last, "failed command gave several beats")
  `VRRB_ASSERT_NEVER(a_fail_nodata, res_fail && res_o.out_data != 64'd0, "failed command carries data")
  `VRRB_ASSERT_IMPLIES(a_clear_busy, !clear_done, busy_o, "command accepted during store clear")

endmodule

FILE: bench/variable_record_ring_buffer_tb.sv
// Self-checking testbench of the variable record ring buffer: directed table, then random traffic.
// Depends on vrrb_pkg and the variable_record_ring_buffer RTL; predicts each result beat itself.
module variable_record_ring_buffer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import vrrb_pkg::*;

  localparam int unsigned RingBytes = 2048;
  localparam int unsigned RingWords = RingBytes / 8;
  localparam int unsigned MaxMsgBytes = RingBytes / 8;
  localparam int unsigned HdrBytes = 8;
  localparam logic [2:0] CmdSpareLo = 3'd5;
  localparam logic [2:0] CmdSpareHi = 3'd7;
  localparam int unsigned StallLimit = 5000;
  localparam int unsigned RandItems = 88;

  logic clk_i, rst_ni, start_i, busy_o, res_valid_o;
  in_t  req_i;
  out_t res_o;

  variable_record_ring_buffer i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .req_i(req_i),
    .busy_o(busy_o), .res_valid_o(res_valid_o), .res_o(res_o)
  );

  // Predictor state
  logic [63:0]     ring_mem [RingWords];
  longint unsigned head_pos, tail_pos, corr_cnt;
  int unsigned     open_idx, open_left, open_len;
  out_t            step_beats[$];
  out_t            pending_beats[$];

  int unsigned err_cnt, stall_cnt, item_cnt;
  bit          quiet;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic out_t beat(logic [1:0] st, logic [30:0] ty, logic [8:0] ln,
                                logic [10:0] idx, logic [63:0] d, logic [62:0] c, logic l);
    return '{st, ty, ln, idx, d, c, l};
  endfunction

  function automatic in_t cmd_of(logic [2:0] c, logic [30:0] ty, logic [11:0] ln,
                                 logic [63:0] d);
    return '{c, ty, ln, d};
  endfunction

  function automatic int unsigned widx(longint unsigned b);
    return int'((b >> 3) & (RingWords - 1));
  endfunction

  function automatic logic [63:0] byte_mask(longint unsigned n);
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic longint unsigned align8(longint unsigned v);
    return (v + 7) & ~64'd7;
  endfunction

  function automatic void put_header(longint unsigned idx, logic [31:0] ty, logic [31:0] ln);
    ring_mem[widx(idx)] = {ty, ln};
  endfunction

  function automatic bit claim(longint unsigned need, output longint unsigned idx);
    longint unsigned used, avail, t_idx, to_end, pad;
    used = tail_pos - head_pos;
    avail = (used >= RingBytes) ? 0 : RingBytes - used;
    t_idx = tail_pos & (RingBytes - 1);
    to_end = RingBytes - t_idx;
    pad = 0;
    idx = 0;
    if (need > avail) return 0;
    if (need > to_end) begin
      if (need > (head_pos & (RingBytes - 1))) return 0;
      pad = to_end;
    end
    tail_pos += need + pad;
    if (pad != 0) begin
      put_header(t_idx, PadType, 32'(pad));
      t_idx = 0;
    end
    idx = t_idx;
    return 1;
  endfunction

  function automatic void predict_read();
    longint unsigned h_idx, contig, nbytes, m_idx, m_len, words, ri;
    logic [31:0] lo, ty, m_type;
    int msgs;
    h_idx = head_pos & (RingBytes - 1);
    contig = RingBytes - h_idx;
    nbytes = 0; m_idx = 0; m_len = 0; m_type = 0; msgs = 0;
    while (nbytes < contig && msgs < 1) begin
      ri = h_idx + nbytes;
      lo = ring_mem[widx(ri)][31:0];
      ty = ring_mem[widx(ri)][63:32];
      if (lo == 0 || lo[31]) break;
      nbytes += align8(lo);
      if (ty == PadType) continue;
      msgs++;
      m_idx = ri;
      m_type = ty;
      m_len = (lo < HdrBytes) ? 0 : lo - HdrBytes;
      if (m_len > MaxMsgBytes) m_len = MaxMsgBytes;
    end
    if (nbytes > contig) nbytes = contig;
    if (msgs == 0) begin
      step_beats.push_back(beat(StNone, 0, 0, 0, 0, 0, 1'b1));
    end else begin
      words = (m_len + 7) / 8;
      step_beats.push_back(beat(StOk, m_type[30:0], 9'(m_len), 0, 0, 0, words == 0));
      for (longint unsigned k = 0; k < words; k++)
        step_beats.push_back(beat(StOk, m_type[30:0], 9'(m_len), 0,
          ring_mem[widx(m_idx + HdrBytes + 8 * k)] & byte_mask(m_len - 8 * k),
          0, k + 1 == words));
    end
    for (longint unsigned i = 0; i < nbytes; i += 8) ring_mem[widx(h_idx + i)] = '0;
    head_pos += nbytes;
  endfunction

  function automatic logic [1:0] predict_unblock();
    longint unsigned cons, prod, lim;
    logic [31:0] lo;
    if (head_pos == tail_pos) return StNone;
    cons = head_pos & (RingBytes - 1);
    prod = tail_pos & (RingBytes - 1);
    lo = ring_mem[widx(cons)][31:0];
    if (lo[31]) begin
      put_header(cons, PadType, 32'd0 - lo);
      if (open_left != 0 && open_idx == cons) open_left = 0;
      return StOk;
    end
    if (lo != 0) return StNone;
    lim = (prod > cons) ? prod : RingBytes;
    for (longint unsigned i = cons + 8; i < lim; i += 8)
      if (ring_mem[widx(i)][31:0] != 0) begin
        put_header(cons, PadType, 32'(i - cons));
        return StOk;
      end
    return StNone;
  endfunction

  // Advance the predicted ring by one command, leaving its result beats in step_beats.
  function automatic void predict_command(in_t c);
    longint unsigned idx, k;
    logic [31:0] rec;
    step_beats.delete();
    case (c.command)
      CmdWriteBegin: begin
        rec = 32'(c.msg_length) + HdrBytes;
        if (c.msg_length > MaxMsgBytes || c.msg_type == 0)
          step_beats.push_back(beat(StError, 0, 0, 0, 0, 0, 1'b1));
        else if (!claim(align8(rec), idx))
          step_beats.push_back(beat(StFull, 0, 0, 0, 0, 0, 1'b1));
        else begin
          put_header(idx, {1'b0, c.msg_type}, 32'd0 - rec);
          open_idx = int'(idx);
          open_len = c.msg_length;
          open_left = (c.msg_length + 7) / 8;
          if (c.msg_length == 0) ring_mem[widx(idx)][31:0] = rec;
          step_beats.push_back(beat(StOk, 0, 0, 11'(idx), 0, 0, 1'b1));
        end
      end
      CmdPayload: begin
        if (open_left == 0) begin
          step_beats.push_back(beat(StError, 0, 0, 0, 0, 0, 1'b1));
        end else begin
          k = (open_len + 7) / 8 - open_left;
          ring_mem[widx(open_idx + HdrBytes + 8 * k)] = c.data_word & byte_mask(open_len - 8 * k);
          open_left--;
          if (open_left == 0) ring_mem[widx(open_idx)][31:0] = open_len + HdrBytes;
          step_beats.push_back(beat(StOk, 0, 0, 11'(open_idx), 0, 0, 1'b1));
        end
      end
      CmdRead: predict_read();
      CmdUnblock: step_beats.push_back(beat(predict_unblock(), 0, 0, 0, 0, 0, 1'b1));
      CmdNextId: begin
        step_beats.push_back(beat(StOk, 0, 0, 0, 0, 63'(corr_cnt), 1'b1));
        corr_cnt++;
      end
      default: step_beats.push_back(beat(StError, 0, 0, 0, 0, 0, 1'b1));
    endcase
  endfunction

  // Hold the command until taken, record its beats, then maybe idle for a burst.
  task automatic issue(in_t c, bit typed = 1'b0, out_t want = '0);
    start_i <= 1'b1;
    req_i <= c;
    do @(posedge clk_i); while (busy_o);
    predict_command(c);
    if (typed) pending_beats.push_back(want);
    else foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    item_cnt++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
  endtask

  // Result checker and stall watchdog
  always @(posedge clk_i) begin
    out_t exp_b;
    if (rst_ni) begin
      if (res_valid_o) begin
        if (pending_beats.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result beat %p", res_o);
        end else begin
          exp_b = pending_beats.pop_front();
          if (res_o.status !== exp_b.status || res_o.out_type !== exp_b.out_type ||
              res_o.out_length !== exp_b.out_length ||
              res_o.rec_index !== exp_b.rec_index ||
              res_o.out_data !== exp_b.out_data ||
              res_o.correlation_id !== exp_b.correlation_id || res_o.last !== exp_b.last) begin
            err_cnt++;
            if (err_cnt <= 10) $display("mismatch: expected %p got %p", exp_b, res_o);
          end
        end
      end
      if (res_valid_o || (start_i && !busy_o)) stall_cnt = 0;
      else stall_cnt++;
      if (stall_cnt >= StallLimit) begin
        $display("variable_record_ring_buffer_tb failed");
        $finish;
      end
    end
  end

  typedef struct {
    in_t  c;
    bit   typed;
    out_t want;
  } dir_row_t;

  initial begin
    dir_row_t rows[$];
    longint unsigned len, n_words, n_sent;
    int unsigned sel;
    logic [30:0] ty;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    err_cnt = 0; stall_cnt = 0; item_cnt = 0; quiet = 0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    head_pos = 0; tail_pos = 0; corr_cnt = 0;
    open_idx = 0; open_left = 0; open_len = 0;

    rows = '{
      '{cmd_of(CmdNextId, 0, 0, 0), 1, beat(StOk, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdNextId, 0, 0, 0), 1, beat(StOk, 0, 0, 0, 0, 1, 1)},
      '{cmd_of(CmdRead, 0, 0, 0), 1, beat(StNone, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdUnblock, 0, 0, 0), 1, beat(StNone, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdPayload, 0, 0, '1), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdWriteBegin, 0, 0, 0), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdWriteBegin, 5, 257, 0), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdWriteBegin, '1, '1, '1), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdSpareLo, 1, 8, 0), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdSpareHi, '1, '1, '1), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdWriteBegin, '1, 0, 0), 1, beat(StOk, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdRead, 0, 0, 0), 1, beat(StOk, '1, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdWriteBegin, 1, 13, 0), 1, beat(StOk, 0, 0, 8, 0, 0, 1)},
      '{cmd_of(CmdPayload, 0, 0, '1), 1, beat(StOk, 0, 0, 8, 0, 0, 1)},
      '{cmd_of(CmdPayload, 0, 0, '1), 1, beat(StOk, 0, 0, 8, 0, 0, 1)},
      '{cmd_of(CmdRead, 0, 0, 0), 0, '0},
      '{cmd_of(CmdWriteBegin, 2, 256, 0), 0, '0},
      '{cmd_of(CmdPayload, 0, 0, 64'h0123_4567_89AB_CDEF), 0, '0},
      '{cmd_of(CmdUnblock, 0, 0, 0), 1, beat(StOk, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdPayload, 0, 0, 0), 1, beat(StError, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdRead, 0, 0, 0), 1, beat(StNone, 0, 0, 0, 0, 0, 1)},
      '{cmd_of(CmdNextId, 0, 0, 0), 1, beat(StOk, 0, 0, 0, 0, 2, 1)}
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) issue(rows[i].c, rows[i].typed, rows[i].want);

    item_cnt = 0;
    while (item_cnt < RandItems) begin
      quiet = (item_cnt + 20 >= RandItems);
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        // well-formed record, now and then left open
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MaxMsgBytes) : $urandom_range(0, 40);
        ty = 31'($urandom_range(1, 32'h7FFF_FFFF));
        issue(cmd_of(CmdWriteBegin, ty, 12'(len), {$urandom, $urandom}));
        n_words = (step_beats[0].status == StOk) ? (len + 7) / 8 : 0;
        n_sent = ($urandom_range(0, 9) == 0) ? $urandom_range(0, n_words) : n_words;
        for (longint unsigned w = 0; w < n_sent; w++)
          issue(cmd_of(CmdPayload, 31'($urandom), 12'($urandom), {$urandom, $urandom}));
      end else if (sel < 70) begin
        issue(cmd_of(CmdRead, 31'($urandom), 12'($urandom), {$urandom, $urandom}));
      end else if (sel < 78) begin
        issue(cmd_of(CmdUnblock, 31'($urandom), 12'($urandom), {$urandom, $urandom}));
      end else if (sel < 85) begin
        issue(cmd_of(CmdNextId, 31'($urandom), 12'($urandom), {$urandom, $urandom}));
      end else begin
        issue(cmd_of(3'($urandom_range(0, 7)), ($urandom_range(0, 3) == 0) ? 31'd0 : 31'($urandom),
                     12'($urandom_range(0, 4095)), {$urandom, $urandom}));
      end
    end

    start_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0 && pending_beats.size() == 0) begin
      $display("variable_record_ring_buffer_tb passed");
    end else begin
      $display("variable_record_ring_buffer_tb failed");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+design
design/vrrb_pkg.sv
design/vrrb_queue.sv
design/vrrb_front.sv
design/vrrb_back.sv
design/variable_record_ring_buffer.sv
bench/variable_record_ring_buffer_tb.sv
